FILE: design/upr_pkg.sv
// ----------------------------------------------------------------------------
// upr_pkg: shared types and constants for the upload packet receiver
// Beat payload structs, response and command codes, phase encoding and the
// byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package upr_pkg;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LIMIT     = 2'd1;

  localparam logic [10:0] MAX_LEN_RESET     = 11'd1024;
  localparam logic [16:0] IMAGE_LIMIT_RESET = 17'd56320;
  localparam logic [10:0] BUF_BYTES         = 11'd1024;

  localparam logic [31:0] SYNC_WORD  = 32'haa03_5539;
  localparam logic [7:0]  REPLY_ACK  = 8'h01;
  localparam logic [7:0]  REPLY_NACK = 8'ha5;

  localparam logic [7:0]  OP_FLASH     = 8'h01;
  localparam logic [7:0]  OP_SYS_RESET = 8'h02;
  localparam logic [7:0]  OP_LOAD      = 8'h03;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // result kinds
  localparam logic [2:0] KIND_SEND      = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
  localparam logic [2:0] KIND_COMMIT    = 3'd2;
  localparam logic [2:0] KIND_RESET_REQ = 3'd3;
  localparam logic [2:0] KIND_START_FW  = 3'd4;

  // input event kinds
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_OUTCOME = 1'b1;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_AWAIT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       flash_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [15:0] commit_offset;
    logic [10:0] commit_length;
    logic        last;
  } out_item_t;

  // up to two results per accepted item
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } res_bundle_t;

  typedef struct packed {
    logic [10:0] max_payload_len;
    logic [16:0] image_limit;
  } cfg_regs_t;

  function automatic out_item_t mk_res(input logic [2:0]  kind,
                                       input logic [7:0]  tx,
                                       input logic [7:0]  pb,
                                       input logic [9:0]  pi,
                                       input logic [15:0] co,
                                       input logic [10:0] cl);
    out_item_t r;
    r.kind          = kind;
    r.tx_byte       = tx;
    r.payload_byte  = pb;
    r.payload_index = pi;
    r.commit_offset = co;
    r.commit_length = cl;
    r.last          = 1'b0;
    return r;
  endfunction

  // MSB-first CRC-16, one byte, eight unrolled shifts
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else                           c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/upr_core.sv
// ----------------------------------------------------------------------------
// upr_core: packet parser
// Sync hunt, header capture, bounds check, payload streaming with CRC and
// commit handshake; turns one item into up to two results in the cycle it is taken.
// ----------------------------------------------------------------------------
module upr_core import upr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  in_item_t             item,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_dat,
  output res_bundle_t          res
);

  localparam logic [10:0] HDR_CMD     = 11'd0;
  localparam logic [10:0] HDR_RSVD    = 11'd1;
  localparam logic [10:0] HDR_LEN_LO  = 11'd2;
  localparam logic [10:0] HDR_LEN_HI  = 11'd3;
  localparam logic [10:0] HDR_OFF_LO  = 11'd4;
  localparam logic [10:0] HDR_OFF_HI  = 11'd5;
  localparam logic [10:0] HDR_CRC_LO  = 11'd6;
  localparam logic [10:0] HDR_BYTES   = 11'd8;

  cfg_regs_t   cfg_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [10:0] count_r, count_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic [7:0]  b;
  logic        is_byte, is_evt;
  logic [10:0] count_inc;
  logic [31:0] shift_in;
  logic        sync_hit;
  logic        hdr_end;
  logic [10:0] lim;
  logic [16:0] span;
  logic        bounds_ok;
  logic        zero_len;
  logic        zero_match;
  logic [15:0] crc_pay;
  logic        pay_end;
  logic        pay_match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload_len <= MAX_LEN_RESET;
      cfg_r.image_limit     <= IMAGE_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_MAX_PAYLOAD_LEN: cfg_r.max_payload_len <= cfg_dat[10:0];
        CFG_IMAGE_LIMIT:     cfg_r.image_limit     <= cfg_dat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      shift_r <= 32'h0;
      count_r <= 11'h0;
      cmd_r   <= 8'h0;
      len_r   <= 16'h0;
      off_r   <= 16'h0;
      exp_r   <= 16'h0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      exp_r   <= exp_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // shared decode
  always_comb begin
    b         = item.rx_byte;
    is_byte   = take && (item.func == FUNC_RX_BYTE);
    is_evt    = take && (item.func == FUNC_OUTCOME);
    count_inc = count_r + 11'd1;
    shift_in  = {shift_r[23:0], b};
    sync_hit  = (shift_in == SYNC_WORD);
    hdr_end   = (count_inc >= HDR_BYTES);

    // header fields including the byte now arriving
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    off_nxt = off_r;
    exp_nxt = exp_r;
    if (is_byte && phase_r == PH_HEADER) begin
      unique case (count_r)
        HDR_CMD:    cmd_nxt = b;
        HDR_RSVD:   ;
        HDR_LEN_LO: len_nxt = {8'h00, b};
        HDR_LEN_HI: len_nxt = {b, len_r[7:0]};
        HDR_OFF_LO: off_nxt = {8'h00, b};
        HDR_OFF_HI: off_nxt = {b, off_r[7:0]};
        HDR_CRC_LO: exp_nxt = {8'h00, b};
        default:    exp_nxt = {b, exp_r[7:0]};
      endcase
    end

    lim        = (cfg_r.max_payload_len > BUF_BYTES) ? BUF_BYTES : cfg_r.max_payload_len;
    span       = {1'b0, off_nxt} + {1'b0, len_nxt};
    bounds_ok  = (len_nxt <= {5'h00, lim}) && (span <= cfg_r.image_limit);
    zero_len   = (len_nxt == 16'h0);
    zero_match = (exp_nxt == CRC_INIT);

    crc_pay    = crc_byte(crc_r, b);
    pay_end    = ({5'h00, count_inc} >= len_r);
    pay_match  = (crc_pay == exp_r);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (is_byte) begin
          shift_nxt = shift_in;
          if (sync_hit) begin
            shift_nxt = 32'h0;
            count_nxt = 11'h0;
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (is_byte) begin
          count_nxt = count_inc;
          if (hdr_end) begin
            phase_nxt = PH_HUNT;
            if (cmd_nxt == OP_FLASH && bounds_ok) begin
              crc_nxt   = CRC_INIT;
              count_nxt = 11'h0;
              phase_nxt = PH_PAYLOAD;
              if (zero_len) phase_nxt = zero_match ? PH_AWAIT : PH_HUNT;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (is_byte) begin
          crc_nxt   = crc_pay;
          count_nxt = count_inc;
          if (pay_end) phase_nxt = pay_match ? PH_AWAIT : PH_HUNT;
        end
      end
      PH_AWAIT: begin
        if (is_evt) phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // results
  always_comb begin
    res.count = 2'd0;
    res.res0  = mk_res(KIND_SEND, REPLY_ACK, 8'h00, 10'h000, 16'h0000, 11'h000);
    res.res1  = res.res0;
    unique case (phase_r)
      PH_HUNT: begin
        if (is_byte && sync_hit) res.count = 2'd1;
      end
      PH_HEADER: begin
        if (is_byte && hdr_end) begin
          res.count = 2'd1;
          unique case (cmd_nxt)
            OP_FLASH: begin
              if (!bounds_ok) begin
                res.res0 = mk_res(KIND_SEND, REPLY_NACK, 8'h00, 10'h000, 16'h0000, 11'h000);
              end else if (zero_len) begin
                res.count = 2'd2;
                if (zero_match)
                  res.res1 = mk_res(KIND_COMMIT, 8'h00, 8'h00, 10'h000, off_nxt,
                                    len_nxt[10:0]);
                else
                  res.res1 = mk_res(KIND_SEND, REPLY_NACK, 8'h00, 10'h000, 16'h0000,
                                    11'h000);
              end
            end
            OP_SYS_RESET: begin
              res.count = 2'd2;
              res.res1  = mk_res(KIND_RESET_REQ, 8'h00, 8'h00, 10'h000, 16'h0000, 11'h000);
            end
            OP_LOAD: begin
              res.count = 2'd2;
              res.res1  = mk_res(KIND_START_FW, 8'h00, 8'h00, 10'h000, 16'h0000, 11'h000);
            end
            default: begin
              res.res0 = mk_res(KIND_SEND, REPLY_NACK, 8'h00, 10'h000, 16'h0000, 11'h000);
            end
          endcase
        end
      end
      PH_PAYLOAD: begin
        if (is_byte) begin
          res.count = 2'd1;
          res.res0  = mk_res(KIND_PAYLOAD, 8'h00, b, count_r[9:0], 16'h0000, 11'h000);
          if (pay_end) begin
            res.count = 2'd2;
            if (pay_match)
              res.res1 = mk_res(KIND_COMMIT, 8'h00, 8'h00, 10'h000, off_r, len_r[10:0]);
            else
              res.res1 = mk_res(KIND_SEND, REPLY_NACK, 8'h00, 10'h000, 16'h0000, 11'h000);
          end
        end
      end
      PH_AWAIT: begin
        if (is_evt) begin
          res.count = 2'd1;
          res.res0  = mk_res(KIND_SEND, item.flash_ok ? REPLY_ACK : REPLY_NACK, 8'h00,
                             10'h000, 16'h0000, 11'h000);
        end
      end
      default: ;
    endcase
    if (res.count == 2'd1) res.res0.last = 1'b1;
    if (res.count == 2'd2) res.res1.last = 1'b1;
  end

endmodule

FILE: design/upr_out_fifo.sv
// ----------------------------------------------------------------------------
// upr_out_fifo: result queue
// Takes up to two results a cycle, hands out one beat a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module upr_out_fifo import upr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  res_bundle_t push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  out_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0] rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIFO_PTR_W-1:0] wr_p1;
  logic                  pop;

  always_comb begin
    pop       = (cnt_r != '0) && !out_stall;
    wr_p1     = wr_r + FIFO_PTR_W'(1);
    wr_nxt    = wr_r + FIFO_PTR_W'(push.count);
    rd_nxt    = pop ? rd_r + FIFO_PTR_W'(1) : rd_r;
    cnt_nxt   = cnt_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    out_valid = (cnt_r != '0);
    out_data  = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_r]  <= push.res0;
    if (push.count == 2'd2) mem_r[wr_p1] <= push.res1;
  end

endmodule

FILE: design/upload_packet_receiver.sv
// ----------------------------------------------------------------------------
// upload_packet_receiver: serial upload packet receiver
// Finds the sync word, parses the 8-byte header, streams payload bytes with
// a running CRC-16/CCITT-FALSE and drives ACK/NACK, commit and boot requests.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload             direction
//  in_      in_valid / in_stall  in_item_t  in_data   event beat in
//  out_     out_valid/out_stall  out_item_t out_data  result beat out
//  cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data  register write in
//
//  One item a cycle while in_stall is low: an accepted beat waits in the input
//  register until taken, the parser turns it into 0..2 results in a single
//  pass, and those land in a four-entry result queue, which drains one beat a
//  cycle while out_stall is low; two results from one item take two beats.
//  in_stall rises only when the queue has fewer than two free slots.
//  Synchronous active-low reset; no clearing pass, usable the cycle after.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module upload_packet_receiver import upr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input events
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  in_item_t    item_r;
  logic        full_r, full_nxt;
  logic        room;
  logic        take;
  logic        accept;
  res_bundle_t res;

  // parser consumes the held beat whenever two result slots are free
  assign take      = full_r && room;
  assign in_stall  = full_r && !room;
  assign accept    = in_valid && !in_stall;
  assign full_nxt  = accept || (full_r && !take);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else        full_r <= full_nxt;
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  upr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (item_r),
    .cfg_wr  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_dat (cfg_data),
    .res     (res)
  );

  upr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/upr_checker.sv
// ----------------------------------------------------------------------------
// upr_checker: port-level checks for the upload packet receiver
// Watches the result and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
module upr_checker import upr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_ready
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // queue empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_resp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_SEND |->
      (out_data.tx_byte == REPLY_ACK || out_data.tx_byte == REPLY_NACK))
    else $error("bad response byte");

  // reset and start requests always end their item
  a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_RESET_REQ || out_data.kind == KIND_START_FW) |->
      out_data.last && out_data.tx_byte == 8'h00)
    else $error("request beat not last");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PAYLOAD |->
      out_data.tx_byte == 8'h00 && out_data.commit_offset == 16'h0000 &&
      out_data.commit_length == 11'h000 && cfg_ready)
    else $error("payload beat carries stray fields");

endmodule

bind upload_packet_receiver upr_checker u_chk (.*);

FILE: tb/sv/upload_packet_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upload_packet_receiver_test: self-checking bench for the upload receiver
// Drives sync words, headers, payloads and flash outcome reports with random
// idling on both channels. A scoreboard predicts every result beat and
// checks the output stream in order, field by field.
// ----------------------------------------------------------------------------
module upload_packet_receiver_test;
  import upr_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;     // input register + parse, with margin
  localparam int RANDOM_ITEMS = 320;   // on top of the directed packets
  localparam int TIMEOUT_NS   = 20_000_000;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the receiver state, predicts result beats
  // --------------------------------------------------------------------------
  class packet_scoreboard;
    phase_t      phase;
    logic [31:0] sync_shift;
    logic [10:0] byte_count;
    logic [7:0]  command;
    logic [15:0] pkt_len;
    logic [15:0] pkt_off;
    logic [15:0] crc_want;
    logic [15:0] crc_run;
    logic [10:0] max_len;
    logic [16:0] img_limit;
    out_item_t   pending_results[$];
    out_item_t   step_out[$];
    int          errors;
    int          results_seen;

    function new();
      phase        = PH_HUNT;
      sync_shift   = '0;
      byte_count   = '0;
      command      = '0;
      pkt_len      = '0;
      pkt_off      = '0;
      crc_want     = '0;
      crc_run      = CRC_INIT;
      max_len      = MAX_LEN_RESET;
      img_limit    = IMAGE_LIMIT_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    // CRC-16/CCITT-FALSE, bit-serial, MSB first
    static function logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    static function out_item_t beat_of(input logic [2:0] kind, input logic [7:0] tx,
                                       input logic [7:0] pb, input logic [9:0] pi,
                                       input logic [15:0] co, input logic [10:0] cl);
      out_item_t r;
      r.kind          = kind;
      r.tx_byte       = tx;
      r.payload_byte  = pb;
      r.payload_index = pi;
      r.commit_offset = co;
      r.commit_length = cl;
      r.last          = 1'b0;
      return r;
    endfunction

    static function out_item_t reply(input logic [7:0] tx);
      return beat_of(KIND_SEND, tx, 8'h00, 10'h000, 16'h0000, 11'h000);
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_MAX_PAYLOAD_LEN) max_len = val[10:0];
      else if (idx == CFG_IMAGE_LIMIT) img_limit = val;
    endfunction

    // end of payload: commit request on a CRC match, NACK otherwise
    function void crc_verdict();
      if (crc_run == crc_want) begin
        step_out.push_back(beat_of(KIND_COMMIT, 8'h00, 8'h00, 10'h000, pkt_off, pkt_len[10:0]));
        phase = PH_AWAIT;
      end else begin
        step_out.push_back(reply(REPLY_NACK));
        phase = PH_HUNT;
      end
    endfunction

    function void note_event(input in_item_t ev);
      logic [7:0]  b;
      logic [10:0] cap;
      out_item_t   tail;
      b = ev.rx_byte;
      step_out.delete();
      if (ev.func == FUNC_OUTCOME) begin
        // outcome reports only count while a commit is outstanding
        if (phase == PH_AWAIT) begin
          step_out.push_back(reply(ev.flash_ok ? REPLY_ACK : REPLY_NACK));
          phase = PH_HUNT;
        end
      end else begin
        case (phase)
          PH_HEADER: begin
            case (byte_count)
              11'd0:   command = b;
              11'd2:   pkt_len = {8'h00, b};
              11'd3:   pkt_len[15:8] = b;
              11'd4:   pkt_off = {8'h00, b};
              11'd5:   pkt_off[15:8] = b;
              11'd6:   crc_want = {8'h00, b};
              11'd7:   crc_want[15:8] = b;
              default: ;
            endcase
            byte_count = byte_count + 11'd1;
            if (byte_count >= 11'd8) begin
              if (command == OP_FLASH) begin
                cap = (max_len > BUF_BYTES) ? BUF_BYTES : max_len;
                if (pkt_len > {5'd0, cap} ||
                    ({2'b00, pkt_off} + {2'b00, pkt_len}) > {1'b0, img_limit}) begin
                  step_out.push_back(reply(REPLY_NACK));
                  phase = PH_HUNT;
                end else begin
                  step_out.push_back(reply(REPLY_ACK));
                  crc_run    = CRC_INIT;
                  byte_count = '0;
                  phase      = PH_PAYLOAD;
                  if (pkt_len == 16'h0000) crc_verdict();
                end
              end else begin
                phase = PH_HUNT;
                step_out.push_back(reply((command == OP_SYS_RESET || command == OP_LOAD)
                                         ? REPLY_ACK : REPLY_NACK));
                if (command == OP_SYS_RESET)
                  step_out.push_back(beat_of(KIND_RESET_REQ, 8'h00, 8'h00, 10'h000,
                                             16'h0000, 11'h000));
                else if (command == OP_LOAD)
                  step_out.push_back(beat_of(KIND_START_FW, 8'h00, 8'h00, 10'h000,
                                             16'h0000, 11'h000));
              end
            end
          end
          PH_PAYLOAD: begin
            step_out.push_back(beat_of(KIND_PAYLOAD, 8'h00, b, byte_count[9:0],
                                       16'h0000, 11'h000));
            crc_run    = crc16_step(crc_run, b);
            byte_count = byte_count + 11'd1;
            if ({5'd0, byte_count} >= pkt_len) crc_verdict();
          end
          PH_AWAIT: ;
          default: begin
            sync_shift = {sync_shift[23:0], b};
            if (sync_shift == SYNC_WORD) begin
              sync_shift = '0;
              byte_count = '0;
              phase      = PH_HEADER;
              step_out.push_back(reply(REPLY_ACK));
            end
          end
        endcase
      end
      if (step_out.size() > 0) begin
        tail      = step_out.pop_back();
        tail.last = 1'b1;
        step_out.push_back(tail);
      end
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    endfunction

    task cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing expected, kind %0d", got.kind));
        return;
      end
      want = pending_results.pop_front();
      cmp_field("kind", 16'(got.kind), 16'(want.kind));
      cmp_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
      cmp_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      cmp_field("payload_index", 16'(got.payload_index), 16'(want.payload_index));
      cmp_field("commit_offset", got.commit_offset, want.commit_offset);
      cmp_field("commit_length", 16'(got.commit_length), 16'(want.commit_length));
      cmp_field("last", 16'(got.last), 16'(want.last));
      results_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  upload_packet_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  packet_scoreboard sb;
  int items_sent  = 0;   // beats that count toward the stimulus budget
  int burst_left  = 0;   // sender runs with no gaps while non-zero
  int stall_run   = 0;
  int settings_no = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted beat, stall in random runs.
  // Values sampled here are the ones the DUT saw at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_run > 0) begin
      stall_run--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      // occasional long stretch with no back-pressure at all
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
    end else begin
      stall_run = pick_len();
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Called just after a rising edge; returns just after the edge
  // that took the beat and its gap. Valid stays high into the next call on a zero gap.
  // --------------------------------------------------------------------------
  task automatic send_beat(input in_item_t ev, input bit counted);
    int gap;
    in_data <= ev;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    if (counted) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(30, 80);
      gap = pick_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic send_rx(input logic [7:0] b, input bit counted);
    in_item_t ev;
    ev.func     = FUNC_RX_BYTE;
    ev.rx_byte  = b;
    ev.flash_ok = 1'($urandom);
    send_beat(ev, counted);
  endtask

  task automatic send_outcome(input logic ok, input bit counted);
    in_item_t ev;
    ev.func     = FUNC_OUTCOME;
    ev.rx_byte  = 8'($urandom);
    ev.flash_ok = ok;
    send_beat(ev, counted);
  endtask

  task automatic send_sync();
    send_rx(SYNC_WORD[31:24], 1'b1);
    send_rx(SYNC_WORD[23:16], 1'b1);
    send_rx(SYNC_WORD[15:8], 1'b1);
    send_rx(SYNC_WORD[7:0], 1'b1);
  endtask

  // little-endian header; the reserved byte is random
  task automatic send_header(input logic [7:0] cmd, input logic [15:0] len,
                             input logic [15:0] off, input logic [15:0] crc);
    send_rx(cmd, 1'b1);
    send_rx(8'($urandom), 1'b1);
    send_rx(len[7:0], 1'b1);
    send_rx(len[15:8], 1'b1);
    send_rx(off[7:0], 1'b1);
    send_rx(off[15:8], 1'b1);
    send_rx(crc[7:0], 1'b1);
    send_rx(crc[15:8], 1'b1);
  endtask

  // Full flash packet. A bad CRC has one bit flipped so it can never match.
  task automatic flash_packet(input int len, input int off, input bit good,
                              input bit with_payload);
    logic [7:0]  data[$];
    logic [7:0]  d;
    logic [15:0] crc;
    crc = CRC_INIT;
    if (with_payload) begin
      for (int i = 0; i < len; i++) begin
        d = 8'($urandom);
        data.push_back(d);
        crc = packet_scoreboard::crc16_step(crc, d);
      end
    end else begin
      crc = 16'($urandom);
    end
    if (!good) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_sync();
    send_header(OP_FLASH, 16'(len), 16'(off), crc);
    foreach (data[i]) send_rx(data[i], 1'b1);
  endtask

  task automatic command_packet(input logic [7:0] cmd);
    send_sync();
    send_header(cmd, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Hold the sender until every predicted beat has arrived, then let any
  // beat that causes no result clear the pipeline.
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    if (!cfg_valid) cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // only ever called with the block idle
  task automatic apply_settings(input logic [10:0] len_lim, input logic [16:0] img_lim);
    logic [CFG_DAT_W-1:0] len_word;
    wait_idle();
    len_word = 17'(len_lim);
    // bits above the register width are dropped by the block
    if ($urandom_range(0, 3) == 0) len_word[16:11] = 6'($urandom);
    cfg_write(CFG_MAX_PAYLOAD_LEN, len_word);
    if ($urandom_range(0, 2) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 17'($urandom));
    cfg_write(CFG_IMAGE_LIMIT, img_lim);
    cfg_valid <= 1'b0;
  endtask

  // extremes first, then the reset values, then random settings
  task automatic next_settings();
    case (settings_no)
      0:       apply_settings(11'd0, 17'd131071);
      1:       apply_settings(11'd2047, 17'd131071);
      2:       apply_settings(11'd1024, 17'd0);
      3:       apply_settings(11'd1023, 17'd1);
      4:       apply_settings(MAX_LEN_RESET, IMAGE_LIMIT_RESET);
      default: apply_settings(11'($urandom_range(0, 2047)), 17'($urandom));
    endcase
    settings_no++;
  endtask

  // Flash packet, mostly good and within the current limits, then mostly the outcome.
  task automatic flash_sequence();
    int cap;
    int len;
    int hi;
    int off;
    bit fits;
    cap = (sb.max_len > BUF_BYTES) ? BUF_BYTES : sb.max_len;
    len = $urandom_range(0, (cap < 24) ? cap : 24);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, (cap < 200) ? cap : 200);
    fits = (sb.img_limit >= len);
    off  = 0;
    if (fits) begin
      hi  = sb.img_limit - len;
      if (hi > 65535) hi = 65535;
      off = $urandom_range(0, hi);
    end
    flash_packet(len, off, $urandom_range(0, 6) != 0, fits || len <= 32);
    // bytes while the commit is outstanding are dropped
    repeat ($urandom_range(0, 2)) send_rx(8'($urandom), 1'b0);
    if ($urandom_range(0, 7) != 0) send_outcome(1'($urandom), 1'b0);
  endtask

  // Header that breaks the length or the image bound. Short payloads are
  // sent anyway: after the NACK they must be treated as line noise.
  task automatic bounds_fail_sequence();
    int cap;
    int img;
    int len;
    int off;
    int lo;
    cap = (sb.max_len > BUF_BYTES) ? BUF_BYTES : sb.max_len;
    img = sb.img_limit;
    len = $urandom_range(0, (cap < 16) ? cap : 16);
    lo  = img - len + 1;
    if (lo < 0) lo = 0;
    if ($urandom_range(0, 1) == 0 && lo <= 65535) begin
      off = $urandom_range(lo, 65535);
    end else begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(cap + 1, 65535)
                                        : cap + $urandom_range(1, 40);
      off = $urandom_range(0, 65535);
    end
    flash_packet(len, off, 1'($urandom), len <= 32);
  endtask

  // random bytes, sometimes a sync word cut short
  task automatic noise_burst();
    if ($urandom_range(0, 2) == 0) begin
      send_rx(SYNC_WORD[31:24], 1'b1);
      send_rx(SYNC_WORD[23:16], 1'b1);
      send_rx(SYNC_WORD[15:8], 1'b1);
    end
    repeat ($urandom_range(1, 8)) send_rx(8'($urandom), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          start;
    int          seq_no;
    int          r;
    logic [7:0]  cmd;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed, on reset register values
    send_outcome(1'b1, 1'b0);                      // outcome with no commit pending
    send_sync();
    send_header(OP_SYS_RESET, 16'hffff, 16'hffff, 16'h0000);
    flash_packet(0, 0, 1'b1, 1'b1);               // zero-length: commit on last header beat
    send_rx(8'h00, 1'b0);                          // dropped while awaiting outcome
    send_outcome(1'b0, 1'b0);

    // a packet exactly at the length limit, then the capped length check
    apply_settings(11'd40, 17'd131071);
    flash_packet(40, 65535, 1'b1, 1'b1);
    send_outcome(1'b1, 1'b0);
    apply_settings(11'd2047, 17'd131071);
    flash_packet(1025, 0, 1'b1, 1'b0);

    // random traffic, settings change every few packets
    start  = items_sent;
    seq_no = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (seq_no % 5 == 0) next_settings();
      seq_no++;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        flash_sequence();
      end else if (r < 65) begin
        bounds_fail_sequence();
      end else if (r < 75) begin
        command_packet($urandom_range(0, 1) ? OP_SYS_RESET : OP_LOAD);
      end else if (r < 82) begin
        do cmd = 8'($urandom); while (cmd == OP_FLASH || cmd == OP_SYS_RESET || cmd == OP_LOAD);
        command_packet(cmd);
      end else if (r < 90) begin
        noise_burst();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 2)) send_outcome(1'($urandom), 1'b0);
      end else begin
        wait_idle();
      end
    end

    // drain; stray beats in the tail are caught by the scoreboard
    wait_idle();
    if (sb.errors == 0) begin
      $display("upload_packet_receiver test passed");
    end else begin
      $display("upload_packet_receiver test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("upload_packet_receiver test failed");
    $finish;
  end

endmodule

FILE: files.f
design/upr_pkg.sv
design/upr_core.sv
design/upr_out_fifo.sv
design/upload_packet_receiver.sv
design/upr_checker.sv
tb/sv/upload_packet_receiver_test.sv
